// ===== src/dwt_analysis_decimator_defines.svh =====
// Assertion macros for the wavelet decimator checker.
// Both macros expect a signal named clk in the scope of use; the second also expects rst.
`ifndef DWT_ANALYSIS_DECIMATOR_DEFINES_SVH
`define DWT_ANALYSIS_DECIMATOR_DEFINES_SVH

// Check on every rising edge, reset included.
`define DWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check on every rising edge outside reset.
`define DWT_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== src/dwt_pkg.sv =====
// Shared types and constants for the one-level wavelet analysis decimator.
// No dependencies; every other file but the defines header imports this package.
package dwt_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int TAP_BITS       = 16;
  localparam int OUT_BITS       = 36;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int TAPS_PER_REG   = 4;
  localparam int TREE_LEAVES    = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXT_MODE  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LP_LOWER  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LP_UPPER  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HP_LOWER  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HP_UPPER  = 3'd5;

  localparam logic [3:0] TAP_COUNT_RESET = 4'd8;
  localparam logic       MODE_REPEAT     = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TAP_BITS-1:0]    coef_t;
  typedef logic signed [OUT_BITS-1:0]    acc_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;
  } dwt_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] approx;
    logic signed [OUT_BITS-1:0] detail;
    logic                       run_end;
    logic                       signal_done;
  } dwt_out_t;

  typedef struct packed {
    logic run_end;
    logic signal_done;
  } dwt_tag_t;

endpackage

// ===== src/dwt_tap_cell.sv =====
// One cell of the delay chain: holds one sample, multiplies it by its two coefficients.
// Depends on dwt_pkg.
module dwt_tap_cell (
  input  logic            clk,
  input  logic            step,
  input  logic            refill,
  input  dwt_pkg::sample_t fill_val,
  input  dwt_pkg::sample_t prev,
  input  logic            load,
  input  logic            active,
  input  dwt_pkg::coef_t  lp,
  input  dwt_pkg::coef_t  hp,
  output dwt_pkg::sample_t tap,
  output dwt_pkg::acc_t   lo_prod,
  output dwt_pkg::acc_t   hi_prod
);
  import dwt_pkg::*;

  sample_t                               x_next;
  logic signed [SAMPLE_BITS+TAP_BITS-1:0] lo_full;
  logic signed [SAMPLE_BITS+TAP_BITS-1:0] hi_full;

  // Products use the value after this step's shift
  assign x_next  = refill ? fill_val : prev;
  assign lo_full = x_next * lp;
  assign hi_full = x_next * hp;

  always_ff @(posedge clk) begin
    if (step) begin
      tap <= x_next;
    end
    if (load) begin
      lo_prod <= active ? acc_t'(lo_full) : '0;
      hi_prod <= active ? acc_t'(hi_full) : '0;
    end
  end

endmodule

// ===== src/dwt_sum_tree.sv =====
// Registered adder tree over the cell products, with the result register at its end.
// Depends on dwt_pkg; stages advance independently so bubbles close up.
module dwt_sum_tree #(
  parameter int MAX_TAPS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dwt_pkg::dwt_tag_t tag_in,
  input  dwt_pkg::acc_t    lo_prod [MAX_TAPS],
  input  dwt_pkg::acc_t    hi_prod [MAX_TAPS],
  output logic             s1_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dwt_pkg::dwt_out_t out_data
);
  import dwt_pkg::*;

  acc_t     lo_leaf [TREE_LEAVES];
  acc_t     hi_leaf [TREE_LEAVES];
  acc_t     lo2 [TREE_LEAVES/2];
  acc_t     hi2 [TREE_LEAVES/2];
  acc_t     lo3 [TREE_LEAVES/4];
  acc_t     hi3 [TREE_LEAVES/4];
  logic     v1, v2, v3;
  dwt_tag_t t1, t2, t3;
  logic     can1, can2, can3, can4;

  for (genvar j = 0; j < TREE_LEAVES; j++) begin : g_leaf
    if (j < MAX_TAPS) begin : g_used
      assign lo_leaf[j] = lo_prod[j];
      assign hi_leaf[j] = hi_prod[j];
    end else begin : g_pad
      assign lo_leaf[j] = '0;
      assign hi_leaf[j] = '0;
    end
  end

  // A stage may load when it is empty or its content moves on
  assign can4     = !out_valid || out_ready;
  assign can3     = !v3 || can4;
  assign can2     = !v2 || can3;
  assign can1     = !v1 || can2;
  assign s1_ready = can1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (can1) v1 <= load;
      if (can2) v2 <= v1;
      if (can3) v3 <= v2;
      if (can4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (can1) begin
      t1 <= tag_in;
    end
    if (can2) begin
      t2 <= t1;
      for (int i = 0; i < TREE_LEAVES/2; i++) begin
        lo2[i] <= lo_leaf[2*i] + lo_leaf[2*i+1];
        hi2[i] <= hi_leaf[2*i] + hi_leaf[2*i+1];
      end
    end
    if (can3) begin
      t3 <= t2;
      for (int i = 0; i < TREE_LEAVES/4; i++) begin
        lo3[i] <= lo2[2*i] + lo2[2*i+1];
        hi3[i] <= hi2[2*i] + hi2[2*i+1];
      end
    end
    if (can4) begin
      out_data.approx      <= lo3[0] + lo3[1];
      out_data.detail      <= hi3[0] + hi3[1];
      out_data.run_end     <= t3.run_end;
      out_data.signal_done <= t3.signal_done;
    end
  end

endmodule

// ===== src/dwt_analysis_decimator.sv =====
// One-level wavelet analysis with decimation by two: top level with step sequencer.
// Depends on dwt_pkg, dwt_tap_cell and dwt_sum_tree.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries samples in order; final_sample
//   closes a signal. coef channel (coef_valid/coef_ready/coef) carries one
//   approximation/detail pair for each odd sample index, flush included.
//   cfg_we/cfg_index/cfg_data write the configuration registers; write only while idle.
// Throughput: one sample per cycle unless the result path stalls. After a final
//   sample the sequencer runs taps_use-1 flush steps (tap_count, 0 read as 1, above
//   MAX_TAPS read as MAX_TAPS), one per cycle unless stalled, before the next is taken.
// Result path: the pair goes through the product register (loaded at the edge that
//   takes the step producing it), two adder levels and the result register, whose
//   valid flag is coef_valid.
// Stall: the result path is a four-stage pipeline that closes bubbles; a step that
//   produces a pair waits only when all four stages are full and coef_ready is low.
//   Steps that produce no pair never wait.
// Reset: rst (synchronous) clears the pipeline, sets tap_count to 8, mode to zero
//   padding and all coefficients to zero; the next sample starts a new signal.
module dwt_analysis_decimator #(
  parameter int MAX_TAPS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  dwt_pkg::dwt_in_t                      item,
  output logic                                  coef_valid,
  input  logic                                  coef_ready,
  output dwt_pkg::dwt_out_t                     coef,
  input  logic                                  cfg_we,
  input  logic [dwt_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [dwt_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import dwt_pkg::*;

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  // Configuration
  logic [3:0] tap_count;
  logic       ext_mode;
  coef_t      lp_coef [MAX_TAPS];
  coef_t      hp_coef [MAX_TAPS];

  // Sequencer state
  logic             busy;
  logic             odd;
  logic             awaiting_first;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] flush_cnt;
  sample_t          ext_val;

  logic [CNT_W-1:0] taps_use;
  logic [CNT_W-1:0] f_now;
  logic [CNT_W-1:0] k_inc;
  logic             emit_idle;
  logic             emit;
  logic             go;
  logic             accept;
  logic             start;
  logic             s1_ready;
  sample_t          step_val;
  sample_t          fill_val;
  dwt_tag_t         tag;

  sample_t tap     [MAX_TAPS];
  acc_t    lo_prod [MAX_TAPS];
  acc_t    hi_prod [MAX_TAPS];

  always_comb begin
    if (tap_count == 4'd0) begin
      taps_use = CNT_W'(1);
    end else if (tap_count > MAX_TAPS) begin
      taps_use = CNT_W'(MAX_TAPS);
    end else begin
      taps_use = tap_count[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_COUNT_RESET;
      ext_mode  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TAP_COUNT) tap_count <= cfg_data[3:0];
      if (cfg_index == REG_EXT_MODE)  ext_mode  <= cfg_data[0];
    end
  end

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_coef
    localparam logic [CFG_IDX_BITS-1:0] LP_REG =
      (j < TAPS_PER_REG) ? REG_LP_LOWER : REG_LP_UPPER;
    localparam logic [CFG_IDX_BITS-1:0] HP_REG =
      (j < TAPS_PER_REG) ? REG_HP_LOWER : REG_HP_UPPER;
    localparam int OFS = TAP_BITS * (j % TAPS_PER_REG);

    always_ff @(posedge clk) begin
      if (rst) begin
        lp_coef[j] <= '0;
        hp_coef[j] <= '0;
      end else if (cfg_we) begin
        if (cfg_index == LP_REG) lp_coef[j] <= cfg_data[OFS +: TAP_BITS];
        if (cfg_index == HP_REG) hp_coef[j] <= cfg_data[OFS +: TAP_BITS];
      end
    end
  end

  // Step selection: a sample step when idle, a flush step when busy
  assign start     = awaiting_first;
  assign emit_idle = !awaiting_first && odd;
  assign f_now     = item.final_sample ? CNT_W'(taps_use - 1'b1) : '0;
  assign k_inc     = CNT_W'(k + 1'b1);
  assign item_ready = !busy && (!emit_idle || s1_ready);
  assign accept    = item_valid && item_ready;
  assign fill_val  = (ext_mode == MODE_REPEAT) ? item.sample : '0;

  always_comb begin
    if (busy) begin
      step_val        = ext_val;
      emit            = odd;
      go              = !odd || s1_ready;
      tag.run_end     = odd && ((k == flush_cnt) || (k_inc == flush_cnt));
      tag.signal_done = tag.run_end;
    end else begin
      step_val        = item.sample;
      emit            = emit_idle;
      go              = accept;
      tag.run_end     = emit_idle && (f_now <= CNT_W'(1));
      tag.signal_done = tag.run_end && item.final_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      odd            <= 1'b0;
      awaiting_first <= 1'b1;
      k              <= '0;
      flush_cnt      <= '0;
    end else if (go) begin
      if (busy) begin
        if (k == flush_cnt) begin
          busy           <= 1'b0;
          awaiting_first <= 1'b1;
          odd            <= 1'b0;
        end else begin
          k   <= k_inc;
          odd <= !odd;
        end
      end else if (item.final_sample && (f_now == '0)) begin
        awaiting_first <= 1'b1;
        odd            <= 1'b0;
      end else begin
        awaiting_first <= 1'b0;
        odd            <= start ? 1'b1 : !odd;
        if (item.final_sample) begin
          busy      <= 1'b1;
          k         <= CNT_W'(1);
          flush_cnt <= f_now;
        end
      end
    end
  end

  // Hold the right-edge value for the flush
  always_ff @(posedge clk) begin
    if (accept && item.final_sample) begin
      ext_val <= fill_val;
    end
  end

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    sample_t prev;
    logic    refill;

    if (j == 0) begin : g_head
      assign prev   = step_val;
      assign refill = 1'b0;
    end else begin : g_body
      assign prev   = tap[j-1];
      assign refill = !busy && start;
    end

    dwt_tap_cell u_cell (
      .clk      (clk),
      .step     (go),
      .refill   (refill),
      .fill_val (fill_val),
      .prev     (prev),
      .load     (go && emit),
      .active   (CNT_W'(j) < taps_use),
      .lp       (lp_coef[j]),
      .hp       (hp_coef[j]),
      .tap      (tap[j]),
      .lo_prod  (lo_prod[j]),
      .hi_prod  (hi_prod[j])
    );
  end

  dwt_sum_tree #(
    .MAX_TAPS (MAX_TAPS)
  ) u_tree (
    .clk       (clk),
    .rst       (rst),
    .load      (go && emit),
    .tag_in    (tag),
    .lo_prod   (lo_prod),
    .hi_prod   (hi_prod),
    .s1_ready  (s1_ready),
    .out_valid (coef_valid),
    .out_ready (coef_ready),
    .out_data  (coef)
  );

endmodule

// ===== src/dwt_checker.sv =====
// Port-level checks for dwt_analysis_decimator, attached by bind.
// Depends on dwt_pkg and dwt_analysis_decimator_defines.svh.
`include "dwt_analysis_decimator_defines.svh"

module dwt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_ready,
  input logic                              coef_valid,
  input logic                              coef_ready,
  input dwt_pkg::dwt_out_t                 coef
);
  import dwt_pkg::*;

  // Hold a stalled pair
  `DWT_ASSERT_RUN(a_coef_hold, coef_valid && !coef_ready |=> coef_valid && $stable(coef), "stalled pair changed")

  // The last pair of a signal also closes its sample's run
  `DWT_ASSERT_RUN(a_done_ends_run, coef_valid |-> (!coef.signal_done || coef.run_end), "signal_done without run_end")

  `DWT_ASSERT(a_reset_empty, rst |=> !coef_valid, "pair shown after reset")

  // Out of reset the sequencer is idle and takes a sample at once
  `DWT_ASSERT(a_reset_ready, rst |=> item_ready, "not ready after reset")

endmodule

bind dwt_analysis_decimator dwt_checker u_dwt_checker (.*);

// ===== tb/tb_dwt_analysis_decimator.sv =====
// Self-checking testbench for dwt_analysis_decimator: drives sample transfers,
// predicts every approximation/detail pair and checks the coef channel field by field.
// Depends on dwt_pkg and the decimator RTL.
`timescale 1ns / 1ps

module tb_dwt_analysis_decimator;
  import dwt_pkg::*;

  localparam int      LINE_TAPS   = 8;
  localparam int      DRAIN_WAIT  = 20;
  localparam int      LONG_STALL  = 300;
  localparam int      CYCLE_LIMIT = 200000;
  localparam logic    MODE_ZERO_PAD = 1'b0;
  localparam sample_t SAMPLE_MIN  = 16'h8000;
  localparam sample_t SAMPLE_MAX  = 16'h7fff;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_ready;
  dwt_in_t                  item = '0;
  logic                     coef_valid;
  logic                     coef_ready = 1'b0;
  dwt_out_t                 coef;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  dwt_analysis_decimator dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .coef_valid (coef_valid),
    .coef_ready (coef_ready),
    .coef       (coef),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Register copies and filter state of the predictor
  logic [3:0]   taps_setting = TAP_COUNT_RESET;
  logic         mode_setting = MODE_ZERO_PAD;
  logic [127:0] lowpass_bank = '0;
  logic [127:0] highpass_bank = '0;
  sample_t      history [LINE_TAPS];
  logic         odd_index = 1'b0;
  logic         signal_open = 1'b0;

  dwt_in_t  sample_backlog [$];
  dwt_out_t coef_expected [$];
  dwt_out_t want;
  int       pushed_count = 0;
  int       accepted_count = 0;
  int       fail_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       long_stall_req = 0;
  int       long_stall_ack = 0;
  int       stall_left = 0;
  logic     item_taken = 1'b0;

  function automatic int active_taps();
    int n;
    n = taps_setting;
    if (n < 1) n = 1;
    if (n > LINE_TAPS) n = LINE_TAPS;
    return n;
  endfunction

  function automatic void shift_history(sample_t s);
    int i;
    for (i = LINE_TAPS - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
  endfunction

  function automatic dwt_out_t filter_pair();
    dwt_out_t          r;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    coef_t             c_lo;
    coef_t             c_hi;
    int                j;
    lo = '0;
    hi = '0;
    for (j = 0; j < active_taps(); j++) begin
      c_lo = lowpass_bank[16*j +: 16];
      c_hi = highpass_bank[16*j +: 16];
      lo = lo + c_lo * history[j];
      hi = hi + c_hi * history[j];
    end
    r.approx      = lo[OUT_BITS-1:0];
    r.detail      = hi[OUT_BITS-1:0];
    r.run_end     = 1'b0;
    r.signal_done = 1'b0;
    return r;
  endfunction

  // Advance the filter by one accepted sample and queue the pairs it produces
  function automatic void predict_coefs(dwt_in_t it);
    dwt_out_t pairs [4];
    int       cnt;
    int       i;
    sample_t  ext;
    cnt = 0;
    if (!signal_open) begin
      for (i = 0; i < LINE_TAPS; i++)
        history[i] = (mode_setting == MODE_REPEAT) ? it.sample : sample_t'(0);
      signal_open = 1'b1;
      odd_index = 1'b0;
    end
    shift_history(it.sample);
    if (odd_index) begin
      pairs[cnt] = filter_pair();
      cnt++;
    end
    odd_index = !odd_index;
    if (it.final_sample) begin
      ext = (mode_setting == MODE_REPEAT) ? it.sample : sample_t'(0);
      for (i = 0; i < active_taps() - 1; i++) begin
        shift_history(ext);
        if (odd_index) begin
          pairs[cnt] = filter_pair();
          cnt++;
        end
        odd_index = !odd_index;
      end
      signal_open = 1'b0;
      odd_index = 1'b0;
      if (cnt > 0) pairs[cnt-1].signal_done = 1'b1;
    end
    if (cnt > 0) pairs[cnt-1].run_end = 1'b1;
    for (i = 0; i < cnt; i++) coef_expected.push_back(pairs[i]);
  endfunction

  function automatic void offer_sample(sample_t s, logic last);
    dwt_in_t it;
    it.sample = s;
    it.final_sample = last;
    sample_backlog.push_back(it);
    pushed_count++;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      default: return sample_t'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TAP_COUNT: taps_setting = val[3:0];
      REG_EXT_MODE:  mode_setting = val[0];
      REG_LP_LOWER:  lowpass_bank[63:0] = val;
      REG_LP_UPPER:  lowpass_bank[127:64] = val;
      REG_HP_LOWER:  highpass_bank[63:0] = val;
      REG_HP_UPPER:  highpass_bank[127:64] = val;
      default: ;
    endcase
  endtask

  task automatic pick_random_setup();
    logic [3:0] n;
    case ($urandom_range(5))
      0: n = 4'd0;
      1: n = 4'd15;
      2: n = 4'd1;
      3: n = 4'd8;
      default: n = 4'($urandom_range(15));
    endcase
    write_reg(REG_TAP_COUNT, 64'(n));
    write_reg(REG_EXT_MODE, 64'($urandom_range(1)));
    write_reg(REG_LP_LOWER, {$urandom, $urandom});
    write_reg(REG_LP_UPPER, {$urandom, $urandom});
    write_reg(REG_HP_LOWER, {$urandom, $urandom});
    write_reg(REG_HP_UPPER, {$urandom, $urandom});
  endtask

  // Wait until every sample is taken and every pair has come back, then let flush finish
  task automatic settle();
    while (accepted_count != pushed_count || coef_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Sender: hold the payload until the transfer, then offer the next one or idle
  always @(negedge clk) begin
    if (!rst && (!item_valid || item_taken)) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item       <= sample_backlog.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      coef_ready <= 1'b0;
    end else if (stall_left != 0) begin
      coef_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (long_stall_req != long_stall_ack) begin
      coef_ready     <= 1'b0;
      stall_left     <= LONG_STALL;
      long_stall_ack <= long_stall_req;
    end else begin
      coef_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    item_taken <= item_valid && item_ready;
    if (!rst) begin
      if (item_valid && item_ready) begin
        predict_coefs(item);
        accepted_count++;
      end
      if (coef_valid && coef_ready) begin
        if (coef_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected pair: approx %0d detail %0d run_end %b done %b",
                     coef.approx, coef.detail, coef.run_end, coef.signal_done);
        end else begin
          want = coef_expected.pop_front();
          if (coef.approx !== want.approx || coef.detail !== want.detail ||
              coef.run_end !== want.run_end || coef.signal_done !== want.signal_done) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pair mismatch: approx %0d/%0d detail %0d/%0d run_end %b/%b done %b/%b",
                       want.approx, coef.approx, want.detail, coef.detail,
                       want.run_end, coef.run_end, want.signal_done, coef.signal_done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int ph;
    int k;
    int len;
    int queued;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full length with extreme taps and samples; then a one-sample signal
    write_reg(REG_TAP_COUNT, 64'd8);
    write_reg(REG_EXT_MODE, 64'(MODE_ZERO_PAD));
    write_reg(REG_LP_LOWER, {4{16'h8000}});
    write_reg(REG_LP_UPPER, {4{16'h8000}});
    write_reg(REG_HP_LOWER, {4{16'h7fff}});
    write_reg(REG_HP_UPPER, {4{16'h7fff}});
    for (k = 0; k < 6; k++) offer_sample((k < 3) ? SAMPLE_MIN : SAMPLE_MAX, 1'b0);
    offer_sample(SAMPLE_MIN, 1'b1);
    offer_sample(SAMPLE_MAX, 1'b1);
    settle();

    // One tap: a lone sample gives nothing, a pair of samples gives one result
    write_reg(REG_TAP_COUNT, 64'd1);
    offer_sample(16'sh1234, 1'b1);
    offer_sample(SAMPLE_MIN, 1'b0);
    offer_sample(SAMPLE_MAX, 1'b1);
    settle();

    // Tap count zero acts as one
    write_reg(REG_TAP_COUNT, 64'd0);
    write_reg(REG_LP_LOWER, 64'h0000_0000_5a82_5a82);
    write_reg(REG_HP_LOWER, 64'h0000_0000_a57e_5a82);
    offer_sample(16'sh4000, 1'b0);
    offer_sample(-16'sh2000, 1'b0);
    offer_sample(16'sh0101, 1'b1);
    settle();

    // Tap count above range, zero fill on the left, edge repeat on the right
    write_reg(REG_TAP_COUNT, 64'd15);
    write_reg(REG_LP_UPPER, 64'h7fff_8000_0123_fedc);
    write_reg(REG_HP_UPPER, 64'h8000_7fff_3210_cdef);
    offer_sample(16'sh7000, 1'b0);
    offer_sample(-16'sh0800, 1'b0);
    offer_sample(16'sh0055, 1'b0);
    settle();
    write_reg(REG_EXT_MODE, 64'(MODE_REPEAT));
    offer_sample(-16'sh3000, 1'b0);
    offer_sample(16'sh2aaa, 1'b1);
    offer_sample(SAMPLE_MIN, 1'b0);
    offer_sample(SAMPLE_MAX, 1'b1);
    settle();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        3: begin send_idle_pct = 23; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      pick_random_setup();
      // Last phase: hold the coef side off so the pipeline fills and stalls input
      if (ph == 4) long_stall_req++;
      queued = 0;
      while (queued < 14) begin
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++) offer_sample(rand_sample(), k == len - 1);
        queued += len;
      end
      settle();
    end

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/dwt_pkg.sv
src/dwt_tap_cell.sv
src/dwt_sum_tree.sv
src/dwt_analysis_decimator.sv
src/dwt_checker.sv
tb/tb_dwt_analysis_decimator.sv
